// File: hdl/cia_pkg.sv
// Shared types and constants for the checked integer ALU.
package cia_pkg;

	localparam int unsigned DataW = 32;

	typedef enum logic [2:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_MUL = 3'd2,
		KIND_DIV = 3'd3,
		KIND_NEG = 3'd4
	} kind_t;

	typedef struct packed {
		logic [2:0]              kind;
		logic                    err;
		logic [DataW-1:0]        fast;
		logic signed [2*DataW-1:0] prod;
		logic [DataW-1:0]        rem;
		logic [DataW-1:0]        quo;
		logic [DataW-1:0]        dvs;
		logic                    qneg;
	} work_t;

endpackage

// File: hdl/cia_front.sv
// Entry stage: add, subtract, negate, multiply and divider setup.
module cia_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          kind,
	input  logic signed [31:0]  operand_a,
	input  logic signed [31:0]  operand_b,
	output logic                out_valid,
	input  logic                out_ready,
	output cia_pkg::work_t      out_work
);
	import cia_pkg::*;

	logic        valid_s1;
	work_t       work_s1;
	work_t       work_d;
	logic [32:0] sum, diff, neg;

	assign sum  = {operand_a[31], operand_a} + {operand_b[31], operand_b};
	assign diff = {operand_a[31], operand_a} - {operand_b[31], operand_b};
	assign neg  = 33'd0 - {operand_a[31], operand_a};

	always_comb begin
		work_d      = '0;
		work_d.kind = kind;
		work_d.prod = operand_a * operand_b;
		work_d.quo  = operand_a[31] ? 32'd0 - operand_a : operand_a;
		work_d.dvs  = operand_b[31] ? 32'd0 - operand_b : operand_b;
		work_d.rem  = '0;
		work_d.qneg = operand_a[31] ^ operand_b[31];
		case (kind)
			KIND_ADD: begin
				work_d.fast = sum[31:0];
				work_d.err  = sum[32] != sum[31];
			end
			KIND_SUB: begin
				work_d.fast = diff[31:0];
				work_d.err  = diff[32] != diff[31];
			end
			KIND_NEG: begin
				work_d.fast = neg[31:0];
				work_d.err  = neg[32] != neg[31];
			end
			KIND_MUL: work_d.err = 1'b0;
			KIND_DIV: work_d.err = operand_b == 32'sd0;
			default:  work_d.err = 1'b1;
		endcase
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_s1 <= work_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_work  = work_s1;
endmodule

// File: hdl/cia_div_stage.sv
// One restoring-division step: one quotient bit per stage.
module cia_div_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cia_pkg::work_t in_work,
	output logic           out_valid,
	input  logic           out_ready,
	output cia_pkg::work_t out_work
);
	import cia_pkg::*;

	logic        valid_s1;
	work_t       work_s1;
	work_t       work_d;
	logic [32:0] trial;

	assign trial = {in_work.rem, in_work.quo[31]} - {1'b0, in_work.dvs};

	always_comb begin
		work_d = in_work;
		if (!trial[32]) begin
			work_d.rem = trial[31:0];
			work_d.quo = {in_work.quo[30:0], 1'b1};
		end else begin
			work_d.rem = {in_work.rem[30:0], in_work.quo[31]};
			work_d.quo = {in_work.quo[30:0], 1'b0};
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_s1 <= work_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_work  = work_s1;
endmodule

// File: hdl/cia_back.sv
// Final stage: sign fixup, overflow checks and output register.
module cia_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cia_pkg::work_t     in_work,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result,
	output logic               error
);
	import cia_pkg::*;

	logic        valid_s1;
	logic [31:0] result_s1;
	logic        error_s1;
	logic [31:0] value;
	logic        err;
	logic [31:0] qs;

	assign qs = in_work.qneg ? 32'd0 - in_work.quo : in_work.quo;

	always_comb begin
		value = in_work.fast;
		err   = in_work.err;
		case (in_work.kind)
			KIND_MUL: begin
				value = in_work.prod[31:0];
				err   = !(&in_work.prod[63:31] || ~|in_work.prod[63:31]);
			end
			KIND_DIV: begin
				value = qs;
				err   = in_work.err || (!in_work.qneg && in_work.quo[31]);
			end
			default: ;
		endcase
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result_s1 <= err ? 32'd0 : value;
			error_s1  <= err;
		end
	end

	assign out_valid = valid_s1;
	assign result    = result_s1;
	assign error     = error_s1;
endmodule

// File: hdl/checked_integer_alu.sv
// Checked signed 32-bit integer ALU top level.
// Pipeline: entry stage, 32 divide steps and output stage, each registered.
// Throughput: one transaction per cycle; each stage holds only while its successor is full.
// The 32-step restoring divider pipeline sets the latency.
// Reset: arst_n asynchronously clears all stage valid bits; no results pending.
module checked_integer_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result,
	output logic               error
);
	import cia_pkg::*;

	work_t work [0:DataW];
	logic  vld  [0:DataW];
	logic  rdy  [0:DataW];

	cia_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (vld[0]),
		.out_ready (rdy[0]),
		.out_work  (work[0])
	);

	for (genvar i = 0; i < DataW; i++) begin : g_div
		cia_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.in_work   (work[i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.out_work  (work[i+1])
		);
	end

	cia_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[DataW]),
		.in_ready  (rdy[DataW]),
		.in_work   (work[DataW]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result),
		.error     (error)
	);
endmodule
